[hdl/eth_ipv4_tcp_header_parser_defines.svh]
// Assertion macros for the header parser RTL.
`ifndef ETH_IPV4_TCP_HEADER_PARSER_DEFINES_SVH
`define ETH_IPV4_TCP_HEADER_PARSER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define EPH_ASSERT_HOLDS(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define EPH_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// The consequent must hold in the cycle after reset is applied.
`define EPH_ASSERT_RESET(lbl, clk, rst, cons, msg) \
   lbl: assert property (@(posedge clk) (rst) |=> (cons)) else $error(msg);

`endif

[hdl/eph_pkg.sv]
// Shared constants and types of the Ethernet/IPv4/TCP header parser.
package eph_pkg;

   // Byte counter width and the width of a frame length (one more bit).
   localparam int COUNT_BITS = 17;
   localparam int LEN_BITS   = COUNT_BITS + 1;

   localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

   // Header sizes in bytes.
   localparam logic [7:0] ETH_HDR_BYTES      = 8'd14;
   localparam logic [7:0] IPV4_MIN_HDR_BYTES = 8'd20;
   localparam logic [7:0] TCP_MIN_HDR_BYTES  = 8'd20;

   // Protocol codes and masks.
   localparam logic [15:0] ETYPE_IP4     = 16'h0800;
   localparam logic [3:0]  IP_VER_4      = 4'd4;
   localparam logic [7:0]  PROTO_TCP     = 8'd6;
   localparam logic [15:0] MF_FLAG_MASK  = 16'h2000;
   localparam logic [15:0] FRAG_OFS_BITS = 16'h1FFF;

   // Fixed byte positions of the captured fields, counted from the frame start.
   localparam logic [COUNT_BITS-1:0] POS_ETHERTYPE_HI = COUNT_BITS'(12);
   localparam logic [COUNT_BITS-1:0] POS_ETHERTYPE_LO = COUNT_BITS'(13);
   localparam logic [COUNT_BITS-1:0] POS_VER_IHL      = COUNT_BITS'(14);
   localparam logic [COUNT_BITS-1:0] POS_TOTLEN_HI    = COUNT_BITS'(16);
   localparam logic [COUNT_BITS-1:0] POS_TOTLEN_LO    = COUNT_BITS'(17);
   localparam logic [COUNT_BITS-1:0] POS_FRAG_HI      = COUNT_BITS'(20);
   localparam logic [COUNT_BITS-1:0] POS_FRAG_LO      = COUNT_BITS'(21);
   localparam logic [COUNT_BITS-1:0] POS_PROTO        = COUNT_BITS'(23);

   // The TCP data offset byte sits 12 bytes into the TCP header.
   localparam logic [7:0] TCP_DOFF_BASE = 8'd26;

   // Header fields of a frame as seen at its last byte.
   typedef struct packed {
      logic [LEN_BITS-1:0] frame_len;
      logic [15:0]         ether_type;
      logic [3:0]          ip_version;
      logic [3:0]          ip_ihl_words;
      logic [15:0]         ip_total_length;
      logic [15:0]         frag_word;
      logic [7:0]          ip_proto;
      logic [3:0]          tcp_offset_words;
      logic                tcp_offset_seen;
   } hdr_frame_type;

endpackage

[hdl/eph_req_if.sv]
// Input channel carrying one frame byte per beat.
interface eph_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       last_byte;

   modport source (output valid, output data_byte, output last_byte, input ready);
   modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

[hdl/eph_rsp_if.sv]
// Result channel carrying one parse result per beat.
interface eph_rsp_if;
   logic        valid;
   logic        ready;
   logic        accepted;
   logic [6:0]  tcp_hdr_pos;
   logic [7:0]  pay_start;
   logic [15:0] payload_length;

   modport source (output valid, output accepted, output tcp_hdr_pos,
                   output pay_start, output payload_length, input ready);
   modport sink   (input valid, input accepted, input tcp_hdr_pos,
                   input pay_start, input payload_length, output ready);
endinterface

[hdl/eth_ipv4_tcp_header_parser.sv]
// Top level of the Ethernet/IPv4/TCP header parser.
//
// A frame enters on req_chan one byte per beat, starting at the Ethernet
// destination address; last_byte marks its final byte. Each frame gives one
// beat on rsp_chan: accepted set with the TCP header offset, the payload
// offset and the payload length for unfragmented IPv4 TCP with consistent
// lengths, or all zeros otherwise.
// A byte is taken every cycle unless a last byte waits for a full result slot.
// Each byte passes the input register, where the fields are captured and, for
// the last byte, checked; the checked result is then registered and held on
// rsp_chan until it is taken. The byte counter stops at its maximum on very
// long frames.
// When the receiver stalls, the result holds in its register and bytes of
// the next frame still flow; only the next last byte waits, and then the
// input side stops until the result is taken.
// Synchronous reset empties both registers and clears all frame state.
`include "eth_ipv4_tcp_header_parser_defines.svh"

module eth_ipv4_tcp_header_parser (
   input  logic       clock,
   input  logic       reset,
   eph_req_if.sink    req_chan,
   eph_rsp_if.source  rsp_chan
);

   logic                   out_free;
   logic                   frame_end;
   eph_pkg::hdr_frame_type frame;
   logic                   rsp_accept_shown;
   logic                   rsp_ofs_full;

   // Byte intake and field capture.
   eph_capture u_capture (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .out_free  (out_free),
      .frame_end (frame_end),
      .frame     (frame)
   );

   // Checks and result register.
   eph_check u_check (
      .clock     (clock),
      .reset     (reset),
      .frame_end (frame_end),
      .frame     (frame),
      .out_free  (out_free),
      .rsp_chan  (rsp_chan)
   );

   // An accepted result must leave room for a full IP header and a full TCP header.
   assign rsp_accept_shown = rsp_chan.valid && rsp_chan.accepted;
   assign rsp_ofs_full =
      (rsp_chan.tcp_hdr_pos >= 7'(eph_pkg::ETH_HDR_BYTES + eph_pkg::IPV4_MIN_HDR_BYTES)) &&
      (rsp_chan.pay_start >= 8'(rsp_chan.tcp_hdr_pos) + eph_pkg::TCP_MIN_HDR_BYTES);

   // A frame that ends is reported in the next cycle.
   `EPH_ASSERT_NEXT(a_frame_end_reported, clock, reset, frame_end, rsp_chan.valid, "lost end")

   // An accepted frame has a full IP header and a full TCP header in its offsets.
   `EPH_ASSERT_HOLDS(a_accept_offsets, clock, reset, rsp_accept_shown, rsp_ofs_full, "short hdr")

   // Reset leaves no result pending and the input open.
   `EPH_ASSERT_RESET(a_reset_empty, clock, reset, !rsp_chan.valid && req_chan.ready, "reset")

endmodule

[hdl/eph_capture.sv]
// Input register, byte counter and header field capture.
module eph_capture (
   input  logic                  clock,
   input  logic                  reset,
   eph_req_if.sink               req_chan,
   input  logic                  out_free,
   output logic                  frame_end,
   output eph_pkg::hdr_frame_type frame
);

   logic                          in_valid_ff;
   logic [7:0]                    in_data_ff;
   logic                          in_last_ff;
   logic                          advance;

   logic [eph_pkg::COUNT_BITS-1:0] byte_count_ff;
   logic [eph_pkg::COUNT_BITS-1:0] byte_count_in;
   logic [15:0]                   ether_type_ff, ether_type_in;
   logic [3:0]                    ip_version_ff, ip_version_in;
   logic [3:0]                    ip_ihl_words_ff, ip_ihl_words_in;
   logic [15:0]                   ip_total_length_ff, ip_total_length_in;
   logic [15:0]                   frag_word_ff, frag_word_in;
   logic [7:0]                    ip_proto_ff, ip_proto_in;
   logic [3:0]                    tcp_offset_words_ff, tcp_offset_words_in;
   logic                          tcp_offset_seen_ff, tcp_offset_seen_in;
   logic [7:0]                    tcp_doff_pos;

   // The registered beat moves on unless it ends a frame and the result slot is full.
   assign advance        = in_valid_ff && (!in_last_ff || out_free);
   assign req_chan.ready = !in_valid_ff || advance;
   assign frame_end      = advance && in_last_ff;

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         in_valid_ff <= req_chan.valid;
      end
      if (req_chan.ready) begin
         in_data_ff <= req_chan.data_byte;
         in_last_ff <= req_chan.last_byte;
      end
   end

   // Position of the TCP data offset byte, from the IHL already captured.
   assign tcp_doff_pos = eph_pkg::TCP_DOFF_BASE + 8'({ip_ihl_words_ff, 2'b00});

   // Field values including the byte at the current position.
   always_comb begin
      ether_type_in       = ether_type_ff;
      ip_version_in       = ip_version_ff;
      ip_ihl_words_in     = ip_ihl_words_ff;
      ip_total_length_in  = ip_total_length_ff;
      frag_word_in        = frag_word_ff;
      ip_proto_in         = ip_proto_ff;
      tcp_offset_words_in = tcp_offset_words_ff;
      tcp_offset_seen_in  = tcp_offset_seen_ff;

      unique case (byte_count_ff)
         eph_pkg::POS_ETHERTYPE_HI: ether_type_in[15:8] = in_data_ff;
         eph_pkg::POS_ETHERTYPE_LO: ether_type_in[7:0]  = in_data_ff;
         eph_pkg::POS_VER_IHL: begin
            ip_version_in   = in_data_ff[7:4];
            ip_ihl_words_in = in_data_ff[3:0];
         end
         eph_pkg::POS_TOTLEN_HI: ip_total_length_in[15:8] = in_data_ff;
         eph_pkg::POS_TOTLEN_LO: ip_total_length_in[7:0]  = in_data_ff;
         eph_pkg::POS_FRAG_HI:   frag_word_in[15:8]       = in_data_ff;
         eph_pkg::POS_FRAG_LO:   frag_word_in[7:0]        = in_data_ff;
         eph_pkg::POS_PROTO:     ip_proto_in              = in_data_ff;
         default: ;
      endcase

      // Only positions past the version/IHL byte are matched, so the IHL is settled by then.
      if (byte_count_ff > eph_pkg::POS_VER_IHL &&
          byte_count_ff == eph_pkg::COUNT_BITS'(tcp_doff_pos)) begin
         tcp_offset_words_in = in_data_ff[7:4];
         tcp_offset_seen_in  = 1'b1;
      end

      // The counter stops at its maximum.
      if (byte_count_ff == eph_pkg::COUNT_MAX) begin
         byte_count_in = byte_count_ff;
      end else begin
         byte_count_in = byte_count_ff + 1'b1;
      end
   end

   // Frame state: updated on each moving beat, cleared at the end of a frame.
   always_ff @(posedge clock) begin
      if (reset || frame_end) begin
         byte_count_ff       <= '0;
         ether_type_ff       <= '0;
         ip_version_ff       <= '0;
         ip_ihl_words_ff     <= '0;
         ip_total_length_ff  <= '0;
         frag_word_ff        <= '0;
         ip_proto_ff         <= '0;
         tcp_offset_words_ff <= '0;
         tcp_offset_seen_ff  <= 1'b0;
      end else if (advance) begin
         byte_count_ff       <= byte_count_in;
         ether_type_ff       <= ether_type_in;
         ip_version_ff       <= ip_version_in;
         ip_ihl_words_ff     <= ip_ihl_words_in;
         ip_total_length_ff  <= ip_total_length_in;
         frag_word_ff        <= frag_word_in;
         ip_proto_ff         <= ip_proto_in;
         tcp_offset_words_ff <= tcp_offset_words_in;
         tcp_offset_seen_ff  <= tcp_offset_seen_in;
      end
   end

   // Fields handed to the checker at the last byte.
   always_comb begin
      frame.frame_len        = eph_pkg::LEN_BITS'(byte_count_ff) + 1'b1;
      frame.ether_type       = ether_type_in;
      frame.ip_version       = ip_version_in;
      frame.ip_ihl_words     = ip_ihl_words_in;
      frame.ip_total_length  = ip_total_length_in;
      frame.frag_word        = frag_word_in;
      frame.ip_proto         = ip_proto_in;
      frame.tcp_offset_words = tcp_offset_words_in;
      frame.tcp_offset_seen  = tcp_offset_seen_in;
   end

endmodule

[hdl/eph_check.sv]
// Frame checks, offset arithmetic and the result register.
module eph_check (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   frame_end,
   input  eph_pkg::hdr_frame_type frame,
   output logic                   out_free,
   eph_rsp_if.source              rsp_chan
);

   logic                          rsp_valid_ff;
   logic                          accepted_ff;
   logic [6:0]                    tcp_hdr_pos_ff;
   logic [7:0]                    pay_start_ff;
   logic [15:0]                   payload_length_ff;

   logic [5:0]                    ihl_bytes;
   logic [5:0]                    tcp_bytes;
   logic [6:0]                    hdr_bytes;
   logic [6:0]                    tcp_ofs;
   logic [7:0]                    pay_ofs;
   logic [15:0]                   pay_len;
   logic                          ok;

   // Header lengths and offsets.
   assign ihl_bytes = {frame.ip_ihl_words, 2'b00};
   assign tcp_bytes = {frame.tcp_offset_words, 2'b00};
   assign hdr_bytes = 7'(ihl_bytes) + 7'(tcp_bytes);
   assign tcp_ofs   = 7'(eph_pkg::ETH_HDR_BYTES) + 7'(ihl_bytes);
   assign pay_ofs   = 8'(tcp_ofs) + 8'(tcp_bytes);
   assign pay_len   = frame.ip_total_length - 16'(hdr_bytes);

   // A frame passes only if every check holds.
   always_comb begin
      ok = 1'b1;
      if (frame.frame_len < eph_pkg::LEN_BITS'(eph_pkg::ETH_HDR_BYTES)) ok = 1'b0;
      if (frame.ether_type != eph_pkg::ETYPE_IP4) ok = 1'b0;
      if (frame.frame_len < eph_pkg::LEN_BITS'(eph_pkg::ETH_HDR_BYTES) +
                            eph_pkg::LEN_BITS'(eph_pkg::IPV4_MIN_HDR_BYTES)) ok = 1'b0;
      if (frame.ip_version != eph_pkg::IP_VER_4) ok = 1'b0;
      if (frame.ip_proto != eph_pkg::PROTO_TCP) ok = 1'b0;
      if (8'(ihl_bytes) < eph_pkg::IPV4_MIN_HDR_BYTES) ok = 1'b0;
      if (frame.ip_total_length < 16'(ihl_bytes)) ok = 1'b0;
      if (frame.frame_len < eph_pkg::LEN_BITS'(eph_pkg::ETH_HDR_BYTES) +
                            eph_pkg::LEN_BITS'(frame.ip_total_length)) ok = 1'b0;
      if ((frame.frag_word & eph_pkg::MF_FLAG_MASK) != 16'h0000) ok = 1'b0;
      if ((frame.frag_word & eph_pkg::FRAG_OFS_BITS) != 16'h0000) ok = 1'b0;
      if (frame.frame_len < eph_pkg::LEN_BITS'(tcp_ofs) +
                            eph_pkg::LEN_BITS'(eph_pkg::TCP_MIN_HDR_BYTES)) ok = 1'b0;
      if (!frame.tcp_offset_seen) ok = 1'b0;
      if (8'(tcp_bytes) < eph_pkg::TCP_MIN_HDR_BYTES) ok = 1'b0;
      if (frame.ip_total_length < 16'(hdr_bytes)) ok = 1'b0;
   end

   // The result slot takes a new beat when empty or being drained.
   assign out_free = !rsp_valid_ff || rsp_chan.ready;

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= frame_end;
      end
      if (frame_end) begin
         accepted_ff       <= ok;
         tcp_hdr_pos_ff    <= ok ? tcp_ofs : 7'd0;
         pay_start_ff      <= ok ? pay_ofs : 8'd0;
         payload_length_ff <= ok ? pay_len : 16'd0;
      end
   end

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.accepted       = accepted_ff;
   assign rsp_chan.tcp_hdr_pos    = tcp_hdr_pos_ff;
   assign rsp_chan.pay_start      = pay_start_ff;
   assign rsp_chan.payload_length = payload_length_ff;

endmodule

[dv/eth_ipv4_tcp_header_parser_tb.sv]
// Self-checking testbench for the Ethernet/IPv4/TCP header parser.
module eth_ipv4_tcp_header_parser_tb;
   timeunit 1ns;
   timeprecision 1ps;

   // Header sizes as plain integers for the length arithmetic.
   localparam int ETH_BYTES = eph_pkg::ETH_HDR_BYTES;
   localparam int IP_MIN    = eph_pkg::IPV4_MIN_HDR_BYTES;
   localparam int TCP_MIN   = eph_pkg::TCP_MIN_HDR_BYTES;

   localparam logic [15:0] IP_FLAG_DF       = 16'h4000;
   localparam int          RANDOM_BYTES     = 110;
   localparam int          RANDOM_FRAMES    = 2;
   localparam int          LONG_HOLD_CYCLES = 400;
   localparam int          STALL_LIMIT      = 3000;
   localparam int          DRAIN_CYCLES     = 8;

   typedef enum int {
      PH_STEADY,
      PH_SENDER_IDLE,
      PH_RECEIVER_STALL,
      PH_BOTH_IDLE
   } idle_phase_type;

   typedef struct packed {
      logic [7:0] data;
      logic       last;
   } frame_beat_type;

   typedef struct packed {
      logic        accepted;
      logic [6:0]  tcp_hdr_pos;
      logic [7:0]  pay_start;
      logic [15:0] payload_length;
   } hdr_result_type;

   logic clock;
   logic reset;

   eph_req_if req_chan ();
   eph_rsp_if rsp_chan ();

   eth_ipv4_tcp_header_parser uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   // Frame bytes waiting to be driven, and parse results still owed by the block.
   frame_beat_type frame_bytes_q[$];
   hdr_result_type hdr_results_q[$];

   int  bytes_queued     = 0;
   int  fail_count       = 0;
   int  send_idle_pct    = 0;
   int  recv_stall_pct   = 0;
   bit  long_hold_armed  = 1'b0;
   bit  long_hold_done   = 1'b0;
   int  hold_left        = 0;
   frame_beat_type next_beat;
   hdr_result_type want;

   // Header fields captured so far in the current frame.
   logic [eph_pkg::COUNT_BITS-1:0] frame_pos      = '0;
   logic [15:0]                    cap_ether_type = '0;
   logic [3:0]                     cap_version    = '0;
   logic [3:0]                     cap_ihl        = '0;
   logic [15:0]                    cap_total_len  = '0;
   logic [15:0]                    cap_frag       = '0;
   logic [7:0]                     cap_proto      = '0;
   logic [3:0]                     cap_doff       = '0;
   logic                           cap_doff_valid = 1'b0;

   // Clock generation.
   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // Track one accepted byte; on the last byte, check the frame and queue its result.
   function automatic void parse_frame_byte(input logic [7:0] b, input logic last);
      int             doff_pos;
      int             frame_len;
      int             ip_bytes;
      int             tcp_bytes;
      int             total;
      int             tcp_at;
      int             pay_at;
      bit             ok;
      hdr_result_type res;
      doff_pos = ETH_BYTES + int'(cap_ihl) * 4 + 12;
      case (frame_pos)
         eph_pkg::POS_ETHERTYPE_HI: cap_ether_type[15:8] = b;
         eph_pkg::POS_ETHERTYPE_LO: cap_ether_type[7:0]  = b;
         eph_pkg::POS_VER_IHL: begin
            cap_version = b[7:4];
            cap_ihl     = b[3:0];
         end
         eph_pkg::POS_TOTLEN_HI: cap_total_len[15:8] = b;
         eph_pkg::POS_TOTLEN_LO: cap_total_len[7:0]  = b;
         eph_pkg::POS_FRAG_HI:   cap_frag[15:8]      = b;
         eph_pkg::POS_FRAG_LO:   cap_frag[7:0]       = b;
         eph_pkg::POS_PROTO:     cap_proto           = b;
         default: ;
      endcase
      // The data offset sits 12 bytes into the TCP header, wherever IHL puts it.
      if (frame_pos > eph_pkg::POS_VER_IHL && int'(frame_pos) == doff_pos) begin
         cap_doff       = b[7:4];
         cap_doff_valid = 1'b1;
      end
      if (!last) begin
         if (frame_pos != eph_pkg::COUNT_MAX) frame_pos = frame_pos + 1'b1;
         return;
      end

      frame_len = int'(frame_pos) + 1;
      ip_bytes  = int'(cap_ihl) * 4;
      tcp_bytes = int'(cap_doff) * 4;
      total     = int'(cap_total_len);
      tcp_at    = ETH_BYTES + ip_bytes;
      pay_at    = tcp_at + tcp_bytes;
      ok = frame_len >= ETH_BYTES && cap_ether_type == eph_pkg::ETYPE_IP4 &&
           frame_len >= ETH_BYTES + IP_MIN && cap_version == eph_pkg::IP_VER_4 &&
           cap_proto == eph_pkg::PROTO_TCP && ip_bytes >= IP_MIN &&
           total >= ip_bytes && frame_len >= ETH_BYTES + total &&
           (cap_frag & eph_pkg::MF_FLAG_MASK) == 16'h0 &&
           (cap_frag & eph_pkg::FRAG_OFS_BITS) == 16'h0 &&
           frame_len >= tcp_at + TCP_MIN && cap_doff_valid &&
           tcp_bytes >= TCP_MIN && total >= ip_bytes + tcp_bytes;
      res = '0;
      if (ok) begin
         res.accepted       = 1'b1;
         res.tcp_hdr_pos    = 7'(tcp_at);
         res.pay_start      = 8'(pay_at);
         res.payload_length = 16'(total - ip_bytes - tcp_bytes);
      end
      hdr_results_q.push_back(res);

      frame_pos      = '0;
      cap_ether_type = '0;
      cap_version    = '0;
      cap_ihl        = '0;
      cap_total_len  = '0;
      cap_frag       = '0;
      cap_proto      = '0;
      cap_doff       = '0;
      cap_doff_valid = 1'b0;
   endfunction

   // Build a frame of random bytes with the given header fields placed at their positions.
   task automatic queue_frame(input int flen, input logic [15:0] et, input logic [3:0] ver,
                              input logic [3:0] ihl, input logic [15:0] tot,
                              input logic [15:0] frag, input logic [7:0] proto,
                              input logic [3:0] doff);
      int             i;
      int             doff_at;
      logic [7:0]     b;
      frame_beat_type beat;
      doff_at = ETH_BYTES + int'(ihl) * 4 + 12;
      for (i = 0; i < flen; i++) begin
         b = 8'($urandom_range(255));
         case (i)
            12: b = et[15:8];
            13: b = et[7:0];
            14: b = {ver, ihl};
            16: b = tot[15:8];
            17: b = tot[7:0];
            20: b = frag[15:8];
            21: b = frag[7:0];
            23: b = proto;
            default: ;
         endcase
         if (i == doff_at) b[7:4] = doff;
         beat.data = b;
         beat.last = (i == flen - 1);
         frame_bytes_q.push_back(beat);
      end
      bytes_queued += flen;
   endtask

   // One random frame: half well-formed TCP, a quarter with one field broken, the rest noise.
   task automatic queue_random_frame();
      int          kind;
      int          flen;
      logic [15:0] et;
      logic [3:0]  ver;
      logic [3:0]  ihl;
      logic [15:0] tot;
      logic [15:0] frag;
      logic [7:0]  proto;
      logic [3:0]  doff;
      kind  = $urandom_range(99);
      et    = eph_pkg::ETYPE_IP4;
      ver   = eph_pkg::IP_VER_4;
      proto = eph_pkg::PROTO_TCP;
      ihl   = ($urandom_range(3) == 0) ? 4'($urandom_range(15, 6)) : 4'd5;
      doff  = ($urandom_range(3) == 0) ? 4'($urandom_range(15, 6)) : 4'd5;
      tot   = 16'(int'(ihl) * 4 + int'(doff) * 4 + $urandom_range(24));
      frag  = ($urandom_range(1) == 0) ? IP_FLAG_DF : 16'h0;
      flen  = ETH_BYTES + int'(tot) + $urandom_range(4);
      if (kind < 25) begin
         // Short noise frame with random header fields.
         flen = $urandom_range(60, 1);
         if ($urandom_range(1) == 0) et = 16'($urandom_range(16'hFFFF));
         ver   = 4'($urandom_range(15));
         ihl   = 4'($urandom_range(15));
         tot   = 16'($urandom_range(16'hFFFF));
         frag  = 16'($urandom_range(16'hFFFF));
         proto = 8'($urandom_range(255));
         doff  = 4'($urandom_range(15));
      end else if (kind < 50) begin
         // Well-formed frame with one field broken.
         case ($urandom_range(7))
            0: et    = 16'($urandom_range(16'hFFFF));
            1: ver   = 4'($urandom_range(15));
            2: proto = 8'($urandom_range(255));
            3: ihl   = 4'($urandom_range(15));
            4: tot   = 16'($urandom_range(16'hFFFF));
            5: frag  = 16'($urandom_range(16'hFFFF));
            6: flen  = $urandom_range(flen, 1);
            default: doff = 4'($urandom_range(15));
         endcase
      end
      queue_frame(flen, et, ver, ihl, tot, frag, proto, doff);
   endtask

   // Wait until every byte is taken and every owed result has arrived.
   task automatic wait_drained();
      do @(posedge clock);
      while (frame_bytes_q.size() != 0 || req_chan.valid || hdr_results_q.size() != 0);
   endtask

   // Byte driver: predicts each accepted beat and offers the next one.
   always @(posedge clock) begin
      if (reset) begin
         req_chan.valid     <= 1'b0;
         req_chan.data_byte <= 8'h00;
         req_chan.last_byte <= 1'b0;
      end else begin
         if (req_chan.valid && req_chan.ready)
            parse_frame_byte(req_chan.data_byte, req_chan.last_byte);
         if (!req_chan.valid || req_chan.ready) begin
            if (frame_bytes_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               next_beat = frame_bytes_q.pop_front();
               req_chan.valid     <= 1'b1;
               req_chan.data_byte <= next_beat.data;
               req_chan.last_byte <= next_beat.last;
            end else begin
               req_chan.valid <= 1'b0;
            end
         end
      end
   end

   // Result monitor: checks each accepted beat and drives ready, with one long hold.
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
         hold_left      <= 0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (hdr_results_q.size() == 0) begin
               $error("result beat arrived with no frame outstanding");
               fail_count++;
            end else begin
               want = hdr_results_q.pop_front();
               if (rsp_chan.accepted !== want.accepted) begin
                  $error("accepted: expected %0d, got %0d", want.accepted, rsp_chan.accepted);
                  fail_count++;
               end
               if (rsp_chan.tcp_hdr_pos !== want.tcp_hdr_pos) begin
                  $error("tcp_hdr_pos: expected %0d, got %0d",
                         want.tcp_hdr_pos, rsp_chan.tcp_hdr_pos);
                  fail_count++;
               end
               if (rsp_chan.pay_start !== want.pay_start) begin
                  $error("pay_start: expected %0d, got %0d",
                         want.pay_start, rsp_chan.pay_start);
                  fail_count++;
               end
               if (rsp_chan.payload_length !== want.payload_length) begin
                  $error("payload_length: expected %0d, got %0d",
                         want.payload_length, rsp_chan.payload_length);
                  fail_count++;
               end
            end
         end
         if (long_hold_armed && !long_hold_done) begin
            hold_left      <= LONG_HOLD_CYCLES;
            long_hold_done <= 1'b1;
            rsp_chan.ready <= 1'b0;
         end else if (hold_left != 0) begin
            hold_left      <= hold_left - 1;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   // Watchdog: end the run if neither channel moves a beat for too long.
   initial begin
      int stalled;
      stalled = 0;
      while (stalled < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
            stalled = 0;
         else
            stalled++;
      end
      $display("FAIL");
      $finish;
   end

   // Reset, then directed frames, then random frames under each idling pattern.
   initial begin
      int i;
      int start_bytes;
      int frames;
      idle_phase_type phase;
      req_chan.valid     = 1'b0;
      req_chan.data_byte = 8'h00;
      req_chan.last_byte = 1'b0;
      rsp_chan.ready     = 1'b0;
      reset = 1'b1;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      for (i = 0; i < 4; i++) begin
         phase = idle_phase_type'(i);
         @(posedge clock);
         case (phase)
            PH_STEADY: begin
               send_idle_pct  <= 0;
               recv_stall_pct <= 0;
            end
            PH_SENDER_IDLE: begin
               send_idle_pct  <= 78;
               recv_stall_pct <= 0;
            end
            PH_RECEIVER_STALL: begin
               // The sender keeps offering while the receiver holds off.
               send_idle_pct   <= 0;
               recv_stall_pct  <= 78;
               long_hold_armed <= 1'b1;
            end
            default: begin
               send_idle_pct  <= 26;
               recv_stall_pct <= 26;
            end
         endcase

         if (phase == PH_STEADY) begin
            // A one-byte frame and frames too short for each header.
            queue_frame(1, eph_pkg::ETYPE_IP4, eph_pkg::IP_VER_4, 4'd5, 16'd40, 16'h0,
                        eph_pkg::PROTO_TCP, 4'd5);
            queue_frame(13, eph_pkg::ETYPE_IP4, eph_pkg::IP_VER_4, 4'd5, 16'd40, 16'h0,
                        eph_pkg::PROTO_TCP, 4'd5);
            queue_frame(33, eph_pkg::ETYPE_IP4, eph_pkg::IP_VER_4, 4'd5, 16'd19, 16'h0,
                        eph_pkg::PROTO_TCP, 4'd5);
            // Smallest good frame, with no payload.
            queue_frame(54, eph_pkg::ETYPE_IP4, eph_pkg::IP_VER_4, 4'd5, 16'd40, 16'h0,
                        eph_pkg::PROTO_TCP, 4'd5);
            // Wrong ethertype, version and protocol.
            queue_frame(60, 16'h86DD, eph_pkg::IP_VER_4, 4'd5, 16'd40, 16'h0,
                        eph_pkg::PROTO_TCP, 4'd5);
            queue_frame(60, eph_pkg::ETYPE_IP4, 4'd6, 4'd5, 16'd40, 16'h0,
                        eph_pkg::PROTO_TCP, 4'd5);
            queue_frame(60, eph_pkg::ETYPE_IP4, eph_pkg::IP_VER_4, 4'd5, 16'd40, 16'h0,
                        8'd17, 4'd5);
            // IHL too small, and zero so the data offset lands at its earliest spot.
            queue_frame(60, eph_pkg::ETYPE_IP4, eph_pkg::IP_VER_4, 4'd4, 16'd40, 16'h0,
                        eph_pkg::PROTO_TCP, 4'd5);
            queue_frame(60, eph_pkg::ETYPE_IP4, eph_pkg::IP_VER_4, 4'd0, 16'd40, 16'h0,
                        eph_pkg::PROTO_TCP, 4'd5);
            // Largest IP and TCP headers: the highest offsets.
            queue_frame(134, eph_pkg::ETYPE_IP4, eph_pkg::IP_VER_4, 4'd15, 16'd120, 16'h0,
                        eph_pkg::PROTO_TCP, 4'd15);
            // Total length below IHL, and beyond the frame.
            queue_frame(60, eph_pkg::ETYPE_IP4, eph_pkg::IP_VER_4, 4'd5, 16'd10, 16'h0,
                        eph_pkg::PROTO_TCP, 4'd5);
            queue_frame(60, eph_pkg::ETYPE_IP4, eph_pkg::IP_VER_4, 4'd5, 16'd100, 16'h0,
                        eph_pkg::PROTO_TCP, 4'd5);
            // More-fragments, don't-fragment alone, fragment offset, all flag bits.
            queue_frame(80, eph_pkg::ETYPE_IP4, eph_pkg::IP_VER_4, 4'd5, 16'd60,
                        eph_pkg::MF_FLAG_MASK, eph_pkg::PROTO_TCP, 4'd5);
            queue_frame(80, eph_pkg::ETYPE_IP4, eph_pkg::IP_VER_4, 4'd5, 16'd60, IP_FLAG_DF,
                        eph_pkg::PROTO_TCP, 4'd5);
            queue_frame(80, eph_pkg::ETYPE_IP4, eph_pkg::IP_VER_4, 4'd5, 16'd60, 16'h0001,
                        eph_pkg::PROTO_TCP, 4'd5);
            queue_frame(80, eph_pkg::ETYPE_IP4, eph_pkg::IP_VER_4, 4'd5, 16'd60, 16'hFFFF,
                        eph_pkg::PROTO_TCP, 4'd5);
            // Frame ends inside the TCP header: short of its end, and before the data offset is seen.
            queue_frame(53, eph_pkg::ETYPE_IP4, eph_pkg::IP_VER_4, 4'd5, 16'd39, 16'h0,
                        eph_pkg::PROTO_TCP, 4'd5);
            queue_frame(80, eph_pkg::ETYPE_IP4, eph_pkg::IP_VER_4, 4'd15, 16'd60, 16'h0,
                        eph_pkg::PROTO_TCP, 4'd5);
            // Data offset zero and too small, and total length short of both headers.
            queue_frame(60, eph_pkg::ETYPE_IP4, eph_pkg::IP_VER_4, 4'd5, 16'd40, 16'h0,
                        eph_pkg::PROTO_TCP, 4'd0);
            queue_frame(60, eph_pkg::ETYPE_IP4, eph_pkg::IP_VER_4, 4'd5, 16'd40, 16'h0,
                        eph_pkg::PROTO_TCP, 4'd4);
            queue_frame(80, eph_pkg::ETYPE_IP4, eph_pkg::IP_VER_4, 4'd5, 16'd50, 16'h0,
                        eph_pkg::PROTO_TCP, 4'd10);
            // All header fields at their maximum.
            queue_frame(80, 16'hFFFF, 4'd15, 4'd15, 16'hFFFF, 16'hFFFF, 8'hFF, 4'd15);
         end

         start_bytes = bytes_queued;
         frames = 0;
         while (bytes_queued - start_bytes < RANDOM_BYTES || frames < RANDOM_FRAMES) begin
            queue_random_frame();
            frames++;
         end
         wait_drained();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0 && hdr_results_q.size() == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule

[sim.f]
+incdir+hdl
hdl/eph_pkg.sv
hdl/eph_req_if.sv
hdl/eph_rsp_if.sv
hdl/eph_capture.sv
hdl/eph_check.sv
hdl/eth_ipv4_tcp_header_parser.sv
dv/eth_ipv4_tcp_header_parser_tb.sv
